// ----- rtl/ipmf_pkg.sv -----
// shared types, constants and tables of the plaquette Ising Metropolis engine
// no dependencies
package ipmf_pkg;

  localparam int Side   = 32;
  localparam int CoordW = $clog2(Side);
  localparam int AddrW  = 2 * CoordW;
  localparam int Depth  = Side * Side;
  localparam int DeW    = 21;
  localparam int NbrN   = 9;
  localparam int NbrW   = $clog2(NbrN);

  localparam logic [31:0] Ln2Q28       = 32'd186065279;
  localparam logic [3:0]  ExpTerms     = 4'd12;
  localparam logic [23:0] UnderflowQ12 = 24'd49152;
  localparam logic [28:0] OneQ28       = 29'h1000_0000;

  localparam logic signed [2:0] MagUp   = 3'sd2;
  localparam logic signed [2:0] MagDown = -3'sd2;
  localparam logic signed [2:0] MagZero = 3'sd0;

  typedef logic [CoordW-1:0] coord_t;

  // entry 0 is the site itself, entries 1..8 are neighbors 0..7
  localparam coord_t OffX [NbrN] = '{coord_t'(0), coord_t'(1), coord_t'(0),
    coord_t'(Side - 1), coord_t'(0), coord_t'(1), coord_t'(Side - 1),
    coord_t'(Side - 1), coord_t'(1)};
  localparam coord_t OffY [NbrN] = '{coord_t'(0), coord_t'(0), coord_t'(1),
    coord_t'(0), coord_t'(Side - 1), coord_t'(1), coord_t'(1),
    coord_t'(Side - 1), coord_t'(Side - 1)};

  typedef enum logic [1:0] {
    ActWrite = 2'd0,
    ActRead  = 2'd1,
    ActStep  = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    StIdle,
    StRead,
    StKmul,
    StEnergy,
    StBmul,
    StExpo,
    StReduce,
    StTmul,
    StRecip,
    StBack,
    StCorr,
    StFinal,
    StWb
  } state_e;

  // floor((2^32 - 1) / k), the quotient is fixed up by one compare afterwards
  function automatic logic [31:0] recip(input logic [3:0] k);
    logic [31:0] r;
    case (k)
      4'd1:    r = 32'd4294967295;
      4'd2:    r = 32'd2147483647;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741823;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870911;
      4'd9:    r = 32'd477218588;
      4'd10:   r = 32'd429496729;
      4'd11:   r = 32'd390451572;
      4'd12:   r = 32'd357913941;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/ising_plaquette_metropolis_flip.sv -----
// top level: sequencer, lattice ram and shared multiplier of the metropolis engine
// depends on ipmf_pkg, ipmf_ram, ipmf_mul
//
// Periodic 32x32 Ising lattice with a four-spin plaquette term. Each transaction
// writes, reads or Metropolis-updates one site and gives one result. A Metropolis
// step reads the site and its eight neighbors one per cycle through the single
// lattice ram port, then runs all arithmetic through one shared multiplier: it
// ends once dE <= 0 is found or exp underflows; otherwise it forms the exponent,
// does ln2 range reduction by repeated subtraction, sums 12 Taylor terms (each a
// multiply by r, a multiply by the reciprocal of k and a back-multiply with a
// correction) and compares the result with the random fraction. The input is
// stalled while a transaction is in work; a finished result waits in an output
// register. The lattice has no reset: read only sites (and neighbors) that were
// written; a write to a site never written before gives an undefined mag_change.
module ising_plaquette_metropolis_flip (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [4:0]  site_x_i,
  input  logic [4:0]  site_y_i,
  input  logic        spin_in_i,
  input  logic [15:0] random_fraction_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        spin_out_o,
  output logic        flipped_o,
  output logic signed [2:0] mag_change_o
);

  ipmf_pkg::state_e state_q, state_d;

  logic [15:0] beta_q, kcoef_q;
  logic [1:0]  action_q;
  ipmf_pkg::coord_t x_q, y_q;
  logic        spin_in_q;
  logic [15:0] rnd_q;

  logic [ipmf_pkg::NbrW:0]  cnt_q, cnt_d;
  logic [ipmf_pkg::NbrN-1:0] bits_q, bits_d;
  logic        flip_q, flip_d;
  logic signed [ipmf_pkg::DeW-1:0] de_q, de_d;
  logic [31:0] r_q, r_d;
  logic [4:0]  n_q, n_d;
  logic [28:0] term_q, term_d, t_q, t_d, q0_q, q0_d;
  logic [3:0]  k_q, k_d;
  logic signed [31:0] sum_q, sum_d;

  logic        out_valid_q, out_valid_d;
  logic        spin_out_q, spin_out_d, flipped_q, flipped_d;
  logic signed [2:0] mag_q, mag_d;

  logic        accept;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        ram_we, ram_wdata, ram_rdata;
  logic [ipmf_pkg::AddrW-1:0] ram_addr;
  logic [ipmf_pkg::NbrW-1:0]  nbr_sel;
  ipmf_pkg::coord_t cx, cy;

  // energy terms
  logic [2:0]  jcnt, pcnt;
  logic signed [4:0] jsum;
  logic [31:0] psum_mag;
  logic        pneg;
  logic [16:0] kmag;
  logic [ipmf_pkg::DeW-1:0] kp_mag;
  logic signed [ipmf_pkg::DeW-1:0] kp, inner, de;
  logic [23:0] e_q12;
  logic [29:0] rem;
  logic [28:0] q_fix;
  logic [5:0]  shamt;
  logic [30:0] shifted;
  logic [16:0] expv;
  logic        slot_free;

  assign accept    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ipmf_pkg::StIdle);
  assign slot_free = !out_valid_q || !out_stall_i;

  ipmf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  ipmf_ram #(
    .Width (1),
    .Depth (ipmf_pkg::Depth)
  ) u_lattice (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (state_q == ipmf_pkg::StRead && cnt_q < (ipmf_pkg::NbrW + 1)'(ipmf_pkg::NbrN)) begin
      nbr_sel = cnt_q[ipmf_pkg::NbrW-1:0];
    end else begin
      nbr_sel = '0;
    end
    cx       = x_q + ipmf_pkg::OffX[nbr_sel];
    cy       = y_q + ipmf_pkg::OffY[nbr_sel];
    ram_addr = {cy, cx};
  end

  // neighbor and plaquette sums, bits_q[i+1] is neighbor i
  always_comb begin
    jcnt = 3'(bits_q[1]) + 3'(bits_q[2]) + 3'(bits_q[3]) + 3'(bits_q[4]);
    pcnt = 3'(bits_q[1] ^ bits_q[2] ^ bits_q[5]) + 3'(bits_q[2] ^ bits_q[3] ^ bits_q[6])
         + 3'(bits_q[3] ^ bits_q[4] ^ bits_q[7]) + 3'(bits_q[4] ^ bits_q[1] ^ bits_q[8]);
    jsum = $signed({1'b0, jcnt, 1'b0}) - 5'sd4;
    pneg = (pcnt < 3'd2);
    psum_mag = pneg ? 32'(4 - 2 * pcnt) : 32'(2 * pcnt - 4);
    kmag = kcoef_q[15] ? 17'(32'd65536 - 32'(kcoef_q)) : {1'b0, kcoef_q};
    kp_mag = ipmf_pkg::DeW'(mul_p[17:0]);
    kp = (kcoef_q[15] ^ pneg) ? $signed(ipmf_pkg::DeW'(0) - kp_mag) : $signed(kp_mag);
    inner = (ipmf_pkg::DeW'(jsum) <<< 12) + kp;
    de = bits_q[0] ? (inner <<< 1) : -(inner <<< 1);
    e_q12 = mul_p[35:12];
    rem = 30'(t_q) - mul_p[29:0];
    q_fix = (rem >= 30'(k_q)) ? q0_q + 29'd1 : q0_q;
    shamt = 6'(n_q) + 6'd12;
    shifted = sum_q[30:0] >> shamt;
    expv = sum_q[31] ? 17'd0 : shifted[16:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ipmf_pkg::StIdle;
      out_valid_q <= 1'b0;
      beta_q      <= 16'd4096;
      kcoef_q     <= 16'd0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_index_i) begin
          kcoef_q <= cfg_data_i;
        end else begin
          beta_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q  <= action_i;
      x_q       <= ipmf_pkg::coord_t'(site_x_i);
      y_q       <= ipmf_pkg::coord_t'(site_y_i);
      spin_in_q <= spin_in_i;
      rnd_q     <= random_fraction_i;
    end
    cnt_q      <= cnt_d;
    bits_q     <= bits_d;
    flip_q     <= flip_d;
    de_q       <= de_d;
    r_q        <= r_d;
    n_q        <= n_d;
    term_q     <= term_d;
    t_q        <= t_d;
    q0_q       <= q0_d;
    k_q        <= k_d;
    sum_q      <= sum_d;
    spin_out_q <= spin_out_d;
    flipped_q  <= flipped_d;
    mag_q      <= mag_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    bits_d      = bits_q;
    flip_d      = flip_q;
    de_d        = de_q;
    r_d         = r_q;
    n_d         = n_q;
    term_d      = term_q;
    t_d         = t_q;
    q0_d        = q0_q;
    k_d         = k_q;
    sum_d       = sum_q;
    out_valid_d = out_valid_q && out_stall_i;
    spin_out_d  = spin_out_q;
    flipped_d   = flipped_q;
    mag_d       = mag_q;
    mul_a       = '0;
    mul_b       = '0;
    ram_we      = 1'b0;
    ram_wdata   = 1'b0;

    unique case (state_q)
      ipmf_pkg::StIdle: begin
        if (accept) begin
          cnt_d   = '0;
          flip_d  = 1'b0;
          state_d = ipmf_pkg::StRead;
        end
      end
      ipmf_pkg::StRead: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q != '0) begin
          bits_d[cnt_q[ipmf_pkg::NbrW-1:0] - 1'b1] = ram_rdata;
        end
        if (action_q != ipmf_pkg::ActStep && cnt_q == (ipmf_pkg::NbrW + 1)'(1)) begin
          state_d = ipmf_pkg::StWb;
        end else if (cnt_q == (ipmf_pkg::NbrW + 1)'(ipmf_pkg::NbrN)) begin
          state_d = ipmf_pkg::StKmul;
        end
      end
      ipmf_pkg::StKmul: begin
        mul_a   = 32'(kmag);
        mul_b   = psum_mag;
        state_d = ipmf_pkg::StEnergy;
      end
      ipmf_pkg::StEnergy: begin
        de_d = de;
        if (de <= 0) begin
          flip_d  = 1'b1;
          state_d = ipmf_pkg::StWb;
        end else begin
          state_d = ipmf_pkg::StBmul;
        end
      end
      ipmf_pkg::StBmul: begin
        mul_a   = 32'(beta_q);
        mul_b   = 32'(de_q[ipmf_pkg::DeW-2:0]);
        state_d = ipmf_pkg::StExpo;
      end
      ipmf_pkg::StExpo: begin
        if (e_q12 >= ipmf_pkg::UnderflowQ12) begin
          state_d = ipmf_pkg::StWb;
        end else begin
          r_d     = {e_q12[15:0], 16'd0};
          n_d     = '0;
          state_d = ipmf_pkg::StReduce;
        end
      end
      ipmf_pkg::StReduce: begin
        // one ln2 subtraction per cycle
        if (r_q >= ipmf_pkg::Ln2Q28) begin
          r_d = r_q - ipmf_pkg::Ln2Q28;
          n_d = n_q + 5'd1;
        end else begin
          term_d  = ipmf_pkg::OneQ28;
          sum_d   = 32'(ipmf_pkg::OneQ28);
          k_d     = 4'd1;
          state_d = ipmf_pkg::StTmul;
        end
      end
      ipmf_pkg::StTmul: begin
        mul_a   = 32'(term_q);
        mul_b   = r_q;
        state_d = ipmf_pkg::StRecip;
      end
      ipmf_pkg::StRecip: begin
        t_d     = mul_p[56:28];
        mul_a   = 32'(mul_p[56:28]);
        mul_b   = ipmf_pkg::recip(k_q);
        state_d = ipmf_pkg::StBack;
      end
      ipmf_pkg::StBack: begin
        q0_d    = mul_p[60:32];
        mul_a   = 32'(mul_p[60:32]);
        mul_b   = 32'(k_q);
        state_d = ipmf_pkg::StCorr;
      end
      ipmf_pkg::StCorr: begin
        term_d = q_fix;
        if (k_q[0]) begin
          sum_d = sum_q - $signed(32'(q_fix));
        end else begin
          sum_d = sum_q + $signed(32'(q_fix));
        end
        if (k_q == ipmf_pkg::ExpTerms) begin
          state_d = ipmf_pkg::StFinal;
        end else begin
          k_d     = k_q + 4'd1;
          state_d = ipmf_pkg::StTmul;
        end
      end
      ipmf_pkg::StFinal: begin
        flip_d  = ({1'b0, rnd_q} < expv);
        state_d = ipmf_pkg::StWb;
      end
      ipmf_pkg::StWb: begin
        if (action_q == ipmf_pkg::ActWrite) begin
          ram_we    = 1'b1;
          ram_wdata = spin_in_q;
        end else if (action_q == ipmf_pkg::ActStep) begin
          ram_we    = flip_q;
          ram_wdata = ~bits_q[0];
        end
        if (slot_free) begin
          out_valid_d = 1'b1;
          flipped_d   = 1'b0;
          mag_d       = ipmf_pkg::MagZero;
          spin_out_d  = bits_q[0];
          if (action_q == ipmf_pkg::ActWrite) begin
            spin_out_d = spin_in_q;
            if (spin_in_q != bits_q[0]) begin
              mag_d = spin_in_q ? ipmf_pkg::MagUp : ipmf_pkg::MagDown;
            end
          end else if (action_q == ipmf_pkg::ActStep && flip_q) begin
            spin_out_d = ~bits_q[0];
            flipped_d  = 1'b1;
            mag_d      = bits_q[0] ? ipmf_pkg::MagDown : ipmf_pkg::MagUp;
          end
          state_d = ipmf_pkg::StIdle;
        end
      end
      default: state_d = ipmf_pkg::StIdle;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign spin_out_o   = spin_out_q;
  assign flipped_o    = flipped_q;
  assign mag_change_o = mag_q;

endmodule

// ----- rtl/ipmf_ram.sv -----
// generic single-port ram with registered read
// no dependencies
module ipmf_ram #(
  parameter int Width = 1,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/ipmf_mul.sv -----
// shared 32x32 unsigned multiplier with registered product
// no dependencies
module ipmf_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= 64'(a_i) * 64'(b_i);
  end

  assign p_o = p_q;

endmodule

// ----- tb/sv/ipmf_checker.sv -----
// result checker for the plaquette Ising Metropolis engine: keeps its own lattice
// and register copies, predicts each result and compares it; depends on ipmf_pkg
module ipmf_checker #(
  parameter bit BetaIdx     = 1'b0,
  parameter bit CouplingIdx = 1'b1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [1:0]        action_i,
  input  logic [4:0]        site_x_i,
  input  logic [4:0]        site_y_i,
  input  logic              spin_in_i,
  input  logic [15:0]       random_fraction_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic              spin_out_i,
  input  logic              flipped_i,
  input  logic signed [2:0] mag_change_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam longint unsigned Ln2Fix  = 64'd186065279;
  localparam longint unsigned ExpZero = 64'd49152;
  localparam int              NTerms  = 12;
  localparam int StepDx [8] = '{1, 0, -1, 0, 1, -1, -1, 1};
  localparam int StepDy [8] = '{0, 1, 0, -1, 1, 1, -1, -1};

  typedef struct packed {
    logic              spin;
    logic              flipped;
    logic signed [2:0] mag;
    logic              mag_care;
  } site_result_t;

  logic                spins [32][32];
  bit                  written [32][32];
  logic [15:0]         beta_q12;
  logic signed [15:0]  coupling_q12;
  site_result_t        expected_q [$];

  // exp(-e) with e in Q.12, floored to Q1.16, range reduced by ln2
  function automatic longint unsigned boltzmann_q16(longint unsigned e);
    longint unsigned big, n, r, term;
    longint sum;
    if (e >= ExpZero) return 0;
    big = e << 16;
    n = big / Ln2Fix;
    r = big - n * Ln2Fix;
    term = 64'd1 << 28;
    sum = longint'(term);
    for (int k = 1; k <= NTerms; k++) begin
      term = ((term * r) >> 28) / longint'(k);
      if (k % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    return longint'(sum) >> (n + 12);
  endfunction

  function automatic site_result_t site_update(logic [1:0] act, int x, int y, logic spin_new,
                                               logic [15:0] rnd);
    site_result_t res;
    int old, jsum, psum, de;
    int nb [8];
    longint unsigned e;
    old = spins[y][x] ? 1 : -1;
    res.flipped = 1'b0;
    res.mag = ipmf_pkg::MagZero;
    res.mag_care = 1'b1;
    case (act)
      ipmf_pkg::ActWrite: begin
        // the old spin of a never-written site is undefined
        res.mag_care = written[y][x];
        written[y][x] = 1'b1;
        spins[y][x] = spin_new;
        if (spin_new && old < 0) res.mag = ipmf_pkg::MagUp;
        else if (!spin_new && old > 0) res.mag = ipmf_pkg::MagDown;
      end
      ipmf_pkg::ActStep: begin
        jsum = 0;
        psum = 0;
        for (int i = 0; i < 8; i++)
          nb[i] = spins[(y + 32 + StepDy[i]) % 32][(x + 32 + StepDx[i]) % 32] ? 1 : -1;
        for (int i = 0; i < 4; i++) begin
          jsum += nb[i];
          psum += nb[i] * nb[(i + 1) % 4] * nb[i + 4];
        end
        de = 2 * old * (jsum * 4096 + int'(coupling_q12) * psum);
        if (de <= 0) begin
          res.flipped = 1'b1;
        end else begin
          e = (longint'(beta_q12) * longint'(de)) >> 12;
          if (longint'(rnd) < boltzmann_q16(e)) res.flipped = 1'b1;
        end
        if (res.flipped) begin
          spins[y][x] = (old < 0);
          res.mag = (old < 0) ? ipmf_pkg::MagUp : ipmf_pkg::MagDown;
        end
      end
      default: ;
    endcase
    res.spin = spins[y][x];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    site_result_t want;
    if (!rst_ni) begin
      beta_q12 = 16'd4096;
      coupling_q12 = '0;
      fail_count_o = 0;
      pending_o = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == BetaIdx) beta_q12 = cfg_data_i;
        else if (cfg_index_i == CouplingIdx) coupling_q12 = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result spin=%b flipped=%b mag=%0d", $time,
                   spin_out_i, flipped_i, mag_change_i);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (want.spin !== spin_out_i) begin
            $display("%0t: spin_out expected %b actual %b", $time, want.spin, spin_out_i);
            fail_count_o++;
          end
          if (want.flipped !== flipped_i) begin
            $display("%0t: flipped expected %b actual %b", $time, want.flipped, flipped_i);
            fail_count_o++;
          end
          if (want.mag_care && want.mag !== mag_change_i) begin
            $display("%0t: mag_change expected %0d actual %0d", $time, want.mag,
                     mag_change_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(site_update(action_i, int'(site_x_i), int'(site_y_i),
                                         spin_in_i, random_fraction_i));
      pending_o = expected_q.size();
    end
  end

endmodule

// ----- tb/sv/testbench.sv -----
// stimulus top for the plaquette Ising Metropolis engine: clock, reset, traffic and verdict
// depends on ipmf_pkg, ising_plaquette_metropolis_flip and ipmf_checker
module testbench;

  localparam bit CfgBeta     = 1'b0;
  localparam bit CfgCoupling = 1'b1;
  localparam int CycleLimit  = 1000000;
  localparam int RandomItems = 70;
  localparam int BandFirst   = 30;
  localparam int BandRows    = 16;
  // action code outside the defined set, handled as a read
  localparam logic [1:0] ActSpare = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_index_i = 1'b0;
  logic [15:0]       cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        action_i = ipmf_pkg::ActRead;
  logic [4:0]        site_x_i = '0;
  logic [4:0]        site_y_i = '0;
  logic              spin_in_i = 1'b0;
  logic [15:0]       random_fraction_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              spin_out_o;
  logic              flipped_o;
  logic signed [2:0] mag_change_o;

  int fail_count, pending, accepted_in, accepted_out, cycles;
  int max_gap = 13;
  bit hold_req = 1'b0;

  always #5 clk_i = ~clk_i;

  ising_plaquette_metropolis_flip dut (.*);

  ipmf_checker #(.BetaIdx(CfgBeta), .CouplingIdx(CfgCoupling)) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .action_i, .site_x_i, .site_y_i,
    .spin_in_i, .random_fraction_i, .out_valid_i(out_valid_o), .out_stall_i,
    .spin_out_i(spin_out_o), .flipped_i(flipped_o), .mag_change_i(mag_change_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (in_valid_i && !in_stall_o) accepted_in <= accepted_in + 1;
    if (out_valid_o && !out_stall_i) accepted_out <= accepted_out + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stall before each result, or one long hold on request
  initial begin
    int gap, seen;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (400) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        gap = $urandom_range(0, max_gap);
        out_stall_i = (gap != 0);
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      seen = accepted_out;
      while (accepted_out == seen) @(negedge clk_i);
    end
  end

  task automatic send_site(logic [1:0] act, logic [4:0] x, logic [4:0] y, logic s,
                           logic [15:0] rnd, int gap);
    int target;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    action_i = act;
    site_x_i = x;
    site_y_i = y;
    spin_in_i = s;
    random_fraction_i = rnd;
    in_valid_i = 1'b1;
    target = accepted_in + 1;
    while (accepted_in < target) @(negedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(bit idx, logic [15:0] val);
    drain_results();
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic random_traffic(int count);
    int pick;
    logic [1:0] act;
    logic [15:0] rnd;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) act = ipmf_pkg::ActStep;
      else if (pick < 75) act = ipmf_pkg::ActWrite;
      else if (pick < 93) act = ipmf_pkg::ActRead;
      else act = ActSpare;
      pick = $urandom_range(0, 9);
      if (pick == 0) rnd = 16'd0;
      else if (pick == 1) rnd = 16'hffff;
      else if (pick < 5) rnd = 16'($urandom_range(0, 1023));
      else rnd = 16'($urandom);
      // rows strictly inside the written band, so every neighbor was written
      send_site(act, 5'($urandom),
                5'((BandFirst + 1 + $urandom_range(0, BandRows - 3)) % 32),
                1'($urandom), rnd, $urandom_range(0, max_gap));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // fill a band of rows, wrapping over the edge, so no step reads an unwritten site
    max_gap = 0;
    for (int r = 0; r < BandRows; r++)
      for (int x = 0; x < 32; x++)
        send_site(ipmf_pkg::ActWrite, 5'(x), 5'((BandFirst + r) % 32), 1'($urandom),
                  '0, 0);
    max_gap = 13;

    // directed: corners, both spins, rewrite, reads, code 3, random extremes
    send_site(ipmf_pkg::ActWrite, 5'd0, 5'd0, 1'b1, '0, 2);
    send_site(ipmf_pkg::ActWrite, 5'd31, 5'd31, 1'b0, 16'hffff, 0);
    send_site(ipmf_pkg::ActWrite, 5'd31, 5'd31, 1'b0, '0, 1);
    send_site(ipmf_pkg::ActRead, 5'd31, 5'd31, 1'b1, '0, 0);
    send_site(ActSpare, 5'd0, 5'd0, 1'b0, 16'hffff, 3);
    // aligned plaquette around (5,5): positive dE, acceptance set by the random value
    for (int i = 0; i < 9; i++)
      send_site(ipmf_pkg::ActWrite, 5'(4 + i % 3), 5'(4 + i / 3), 1'b1, '0, 0);
    send_site(ipmf_pkg::ActStep, 5'd5, 5'd5, 1'b0, 16'hffff, 0);
    send_site(ipmf_pkg::ActStep, 5'd5, 5'd5, 1'b0, 16'd0, 1);
    send_site(ipmf_pkg::ActStep, 5'd0, 5'd31, 1'b0, 16'd0, 0);
    send_site(ipmf_pkg::ActStep, 5'd31, 5'd0, 1'b1, 16'hffff, 0);

    write_reg(CfgCoupling, 16'h8000);
    send_site(ipmf_pkg::ActStep, 5'd5, 5'd5, 1'b0, 16'hffff, 0);
    random_traffic(RandomItems);

    // long receiver hold while the sender keeps offering
    hold_req = 1'b1;
    random_traffic(20);

    write_reg(CfgBeta, 16'hffff);
    write_reg(CfgCoupling, 16'h7fff);
    send_site(ipmf_pkg::ActStep, 5'd5, 5'd5, 1'b0, 16'd0, 0);
    random_traffic(RandomItems);

    write_reg(CfgBeta, 16'd0);
    max_gap = 0;
    random_traffic(RandomItems);
    max_gap = 13;

    write_reg(CfgBeta, 16'd300);
    write_reg(CfgCoupling, 16'd2048);
    random_traffic(RandomItems);

    write_reg(CfgBeta, 16'($urandom_range(100, 3000)));
    write_reg(CfgCoupling, 16'($urandom));
    random_traffic(RandomItems);

    write_reg(CfgBeta, 16'd4096);
    write_reg(CfgCoupling, 16'd0);
    random_traffic(RandomItems);

    drain_results();
    repeat (100) @(negedge clk_i);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ipmf_pkg.sv
rtl/ipmf_ram.sv
rtl/ipmf_mul.sv
rtl/ising_plaquette_metropolis_flip.sv
tb/sv/ipmf_checker.sv
tb/sv/testbench.sv
